### design/otss_pkg.sv
// shared types and constants of the obstacle and tilt safety supervisor
package otss_pkg;

    localparam int CFG_DIST_W = 12;
    localparam int CFG_TQ_W   = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 8;
    localparam int QUOT_W     = 8;
    localparam int LIM_W      = 9;
    localparam int SPD_W      = 16;
    localparam int MAG_W      = 17;

    localparam logic [CFG_DIST_W-1:0] STOP_RST = 12'd20;
    localparam logic [CFG_DIST_W-1:0] SLOW_RST = 12'd50;
    localparam logic [CFG_DIST_W-1:0] WARN_RST = 12'd100;
    localparam logic [CFG_TQ_W-1:0]   TQ_LOW_RST  = 15'd50;
    localparam logic [CFG_TQ_W-1:0]   TQ_HIGH_RST = 15'd300;

    localparam int FILT_GAIN  = 77;
    localparam int RAMP_BASE  = 768;
    localparam int RAMP_SLOPE = 1792;
    localparam int RAMP_SCALE = 10;

    localparam logic signed [SPD_W-1:0] DIR_THRESH  = 16'sd5;
    localparam logic [MAG_W-1:0]        MOVE_THRESH = 17'd10;

    localparam logic [LIM_W-1:0] LIM_STOP = 9'd0;
    localparam logic [LIM_W-1:0] LIM_WARN = 9'd204;
    localparam logic [LIM_W-1:0] LIM_FULL = 9'd256;

    typedef enum logic [2:0] {
        SAFE_OK    = 3'd0,
        OBST_FRONT = 3'd1,
        OBST_REAR  = 3'd2,
        TIP_LEFT   = 3'd3,
        TIP_RIGHT  = 3'd4
    } t_safety;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP    = 3'd0,
        CFG_SLOW    = 3'd1,
        CFG_WARN    = 3'd2,
        CFG_TQ_LOW  = 3'd3,
        CFG_TQ_HIGH = 3'd4
    } t_cfg_idx;

    function automatic logic [MAG_W-1:0] mag16(input logic signed [SPD_W-1:0] x);
        logic signed [MAG_W-1:0] e;
        e = {x[SPD_W-1], x};
        return x[SPD_W-1] ? MAG_W'(-e) : MAG_W'(e);
    endfunction

endpackage

### design/otss_filter.sv
// one step of the keep-previous exponential distance filter
module otss_filter import otss_pkg::*; #(
    parameter int DIST_BITS = 12
) (
    input  logic [DIST_BITS-1:0]        i_reading,
    input  logic [DIST_BITS+FRAC_W-1:0] i_prev,
    output logic [DIST_BITS+FRAC_W-1:0] o_next
);

    localparam int SW = DIST_BITS + FRAC_W;
    localparam int DW = SW + 2;
    localparam int PW = SW + 9;

    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] diff_x;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] step;

    always_comb begin
        diff   = $signed({2'b00, i_reading, {FRAC_W{1'b0}}}) - $signed({2'b00, i_prev});
        diff_x = PW'(diff);
        prod   = diff_x * PW'(FILT_GAIN);
        step   = prod >>> FRAC_W;
        if (i_reading == '0) begin
            o_next = i_prev;
        end else if (i_prev == '0) begin
            o_next = {i_reading, {FRAC_W{1'b0}}};
        end else begin
            o_next = i_prev + step[SW-1:0];
        end
    end

endmodule

### design/otss_div.sv
// restoring divider for the speed ramp, one quotient bit per cycle
module otss_div import otss_pkg::*; #(
    parameter int NW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NW-1:0]     i_num,
    input  logic [NW-1:0]     i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NW-1:0]     r_rem;
    logic [NW-1:0]     r_dsh;
    logic [QUOT_W-1:0] r_quot;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W - 1);
                r_rem  <= i_num;
                r_dsh  <= i_den << (QUOT_W - 1);
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quot <= {r_quot[QUOT_W-2:0], ge};
                r_dsh  <= r_dsh >> 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/obstacle_tilt_safety_supervisor_top.sv
// top level of the obstacle and tilt safety supervisor
//
//   channel  direction  handshake             contents
//   input    in         i_valid / o_ready     four distances, targets, torques, actuals
//   result   out        o_valid / i_ready     stop, state, override, change, two limits
//   config   in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// an item passes from accept to result through 4 filter steps in one shared filter
// unit, a decision state, one division per side in the shared divider that forms
// the ramp limit, then the load of the result register; a new item is accepted only
// once the block is back in idle. o_ready is high only while idle; a new item
// is taken while the previous result still waits, and the block waits at the end
// until the result register is free. synchronous active-low reset, no clearing pass
module obstacle_tilt_safety_supervisor_top import otss_pkg::*; #(
    parameter int DIST_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [DIST_BITS-1:0]    i_dist_front_left,
    input  logic [DIST_BITS-1:0]    i_dist_front_right,
    input  logic [DIST_BITS-1:0]    i_dist_rear_left,
    input  logic [DIST_BITS-1:0]    i_dist_rear_right,
    input  logic signed [SPD_W-1:0] i_target_left,
    input  logic signed [SPD_W-1:0] i_target_right,
    input  logic signed [SPD_W-1:0] i_torque_left,
    input  logic signed [SPD_W-1:0] i_torque_right,
    input  logic signed [SPD_W-1:0] i_actual_left,
    input  logic signed [SPD_W-1:0] i_actual_right,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_stop_request,
    output logic [2:0]              o_state_code,
    output logic                    o_override_active,
    output logic                    o_state_changed,
    output logic [LIM_W-1:0]        o_speed_limit_front,
    output logic [LIM_W-1:0]        o_speed_limit_rear,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int SW = DIST_BITS + FRAC_W;
    localparam int QW = CFG_DIST_W + FRAC_W;
    localparam int CW = (SW > QW) ? SW : QW;
    localparam int NW = CW + 12;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FILT   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_DIV_F  = 6'b001000,
        S_DIV_R  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_DIST_W-1:0] r_stop, r_slow, r_warn;
    logic [CFG_TQ_W-1:0]   r_tq_low, r_tq_high;

    logic [SW-1:0]        r_smooth [4];
    logic [DIST_BITS-1:0] r_dist   [4];
    logic [1:0]           r_idx;
    logic                 r_fwd, r_bwd, r_tilt_l, r_tilt_r;
    t_safety              r_safety, n_safety;
    logic                 r_override, n_override;
    logic                 r_stop_res, n_stop_res;
    logic                 r_changed;
    logic [SW-1:0]        r_front, r_rear;
    logic [QUOT_W-1:0]    r_quot_f, r_quot_r;

    logic                 r_o_valid;
    logic                 r_o_stop, r_o_override, r_o_changed;
    logic [2:0]           r_o_state;
    logic [LIM_W-1:0]     r_o_lim_f, r_o_lim_r;

    logic [SW-1:0]        filt_next;
    logic [SW-1:0]        front_min, rear_min;
    logic [CW-1:0]        stop_q, slow_q, warn_q;
    logic [SW-1:0]        div_d;
    logic [CW-1:0]        ramp_den, ramp_num;
    logic [NW-1:0]        div_num, div_den;
    logic                 div_start, div_done;
    logic [QUOT_W-1:0]    div_quot;
    logic [MAG_W-1:0]     mag_ql, mag_qr, mag_al, mag_ar;
    logic                 moving, lift_l, lift_r;
    logic                 in_acc, out_load;
    logic [LIM_W-1:0]     lim_f, lim_r;

    function automatic logic [SW-1:0] side_min(input logic [SW-1:0] a, input logic [SW-1:0] b);
        if (a == '0) begin
            return b;
        end else if (b == '0) begin
            return a;
        end
        return (a < b) ? a : b;
    endfunction

    function automatic logic [LIM_W-1:0] limit_for(
        input logic [SW-1:0]     d,
        input logic [QUOT_W-1:0] q,
        input logic [CW-1:0]     sq,
        input logic [CW-1:0]     lq,
        input logic [CW-1:0]     wq
    );
        logic [CW-1:0] dx;
        dx = CW'(d);
        if (d == '0) begin
            return LIM_FULL;
        end else if (dx < sq) begin
            return LIM_STOP;
        end else if (dx < lq) begin
            return LIM_W'(q);
        end else if (dx < wq) begin
            return LIM_WARN;
        end
        return LIM_FULL;
    endfunction

    assign stop_q = CW'({r_stop, {FRAC_W{1'b0}}});
    assign slow_q = CW'({r_slow, {FRAC_W{1'b0}}});
    assign warn_q = CW'({r_warn, {FRAC_W{1'b0}}});

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_ready);

    // tilt and direction flags from the item fields
    assign mag_ql = mag16(i_torque_left);
    assign mag_qr = mag16(i_torque_right);
    assign mag_al = mag16(i_actual_left);
    assign mag_ar = mag16(i_actual_right);
    assign moving = (mag_al > MOVE_THRESH) || (mag_ar > MOVE_THRESH);
    assign lift_l = moving && (mag_ql < MAG_W'(r_tq_low)) && (mag_qr > MAG_W'(r_tq_high));
    assign lift_r = moving && !lift_l
                    && (mag_qr < MAG_W'(r_tq_low)) && (mag_ql > MAG_W'(r_tq_high));

    otss_filter #(.DIST_BITS(DIST_BITS)) u_filter (
        .i_reading (r_dist[r_idx]),
        .i_prev    (r_smooth[r_idx]),
        .o_next    (filt_next)
    );

    assign front_min = side_min(r_smooth[0], r_smooth[1]);
    assign rear_min  = side_min(r_smooth[2], r_smooth[3]);

    // ramp operands: (768*den + 1792*num) / (10*den)
    assign div_d     = (r_state == S_DECIDE) ? front_min : r_rear;
    assign ramp_den  = slow_q - stop_q;
    assign ramp_num  = CW'(div_d) - stop_q;
    assign div_num   = NW'(ramp_den) * NW'(RAMP_BASE) + NW'(ramp_num) * NW'(RAMP_SLOPE);
    assign div_den   = NW'(ramp_den) * NW'(RAMP_SCALE);
    assign div_start = (r_state == S_DECIDE) || ((r_state == S_DIV_F) && div_done);

    otss_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // safety state decision
    always_comb begin
        n_safety   = r_safety;
        n_override = r_override;
        n_stop_res = 1'b0;
        if (r_fwd && front_min != '0 && CW'(front_min) < stop_q) begin
            n_safety   = OBST_FRONT;
            n_stop_res = 1'b1;
            if (r_safety != OBST_FRONT) begin
                n_override = 1'b1;
            end
        end else if (r_bwd && rear_min != '0 && CW'(rear_min) < stop_q) begin
            n_safety   = OBST_REAR;
            n_stop_res = 1'b1;
            if (r_safety != OBST_REAR) begin
                n_override = 1'b1;
            end
        end else if (r_tilt_l) begin
            n_safety   = TIP_LEFT;
            n_override = 1'b1;
            n_stop_res = 1'b1;
        end else if (r_tilt_r) begin
            n_safety   = TIP_RIGHT;
            n_override = 1'b1;
            n_stop_res = 1'b1;
        end else if (r_safety != SAFE_OK) begin
            n_safety   = SAFE_OK;
            n_override = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                if (r_idx == 2'd3) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_DIV_F;
            S_DIV_F: begin
                if (div_done) begin
                    n_state = S_DIV_R;
                end
            end
            S_DIV_R: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign lim_f = limit_for(r_front, r_quot_f, stop_q, slow_q, warn_q);
    assign lim_r = limit_for(r_rear, r_quot_r, stop_q, slow_q, warn_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stop      <= STOP_RST;
            r_slow      <= SLOW_RST;
            r_warn      <= WARN_RST;
            r_tq_low    <= TQ_LOW_RST;
            r_tq_high   <= TQ_HIGH_RST;
            r_smooth[0] <= '0;
            r_smooth[1] <= '0;
            r_smooth[2] <= '0;
            r_smooth[3] <= '0;
            r_safety    <= SAFE_OK;
            r_override  <= 1'b0;
            r_idx       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_STOP:    r_stop    <= i_cfg_data[CFG_DIST_W-1:0];
                    CFG_SLOW:    r_slow    <= i_cfg_data[CFG_DIST_W-1:0];
                    CFG_WARN:    r_warn    <= i_cfg_data[CFG_DIST_W-1:0];
                    CFG_TQ_LOW:  r_tq_low  <= i_cfg_data[CFG_TQ_W-1:0];
                    CFG_TQ_HIGH: r_tq_high <= i_cfg_data[CFG_TQ_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_dist[0] <= i_dist_front_left;
                r_dist[1] <= i_dist_front_right;
                r_dist[2] <= i_dist_rear_left;
                r_dist[3] <= i_dist_rear_right;
                r_fwd     <= (i_target_left > DIR_THRESH) || (i_target_right > DIR_THRESH);
                r_bwd     <= (i_target_left < -DIR_THRESH) || (i_target_right < -DIR_THRESH);
                r_tilt_l  <= lift_l;
                r_tilt_r  <= lift_r;
                r_idx     <= '0;
            end

            if (r_state == S_FILT) begin
                r_smooth[r_idx] <= filt_next;
                r_idx           <= r_idx + 1'b1;
            end

            if (r_state == S_DECIDE) begin
                r_safety   <= n_safety;
                r_override <= n_override;
                r_stop_res <= n_stop_res;
                r_changed  <= (n_safety != r_safety);
                r_front    <= front_min;
                r_rear     <= rear_min;
            end

            if (r_state == S_DIV_F && div_done) begin
                r_quot_f <= div_quot;
            end
            if (r_state == S_DIV_R && div_done) begin
                r_quot_r <= div_quot;
            end

            if (out_load) begin
                r_o_valid    <= 1'b1;
                r_o_stop     <= r_stop_res;
                r_o_state    <= r_safety;
                r_o_override <= r_override;
                r_o_changed  <= r_changed;
                r_o_lim_f    <= lim_f;
                r_o_lim_r    <= lim_r;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid             = r_o_valid;
    assign o_stop_request      = r_o_stop;
    assign o_state_code        = r_o_state;
    assign o_override_active   = r_o_override;
    assign o_state_changed     = r_o_changed;
    assign o_speed_limit_front = r_o_lim_f;
    assign o_speed_limit_rear  = r_o_lim_r;

endmodule
